// File: src/stma_pkg.sv
package stma_pkg;

  localparam int RowW   = 8;
  localparam int ColW   = 8;
  localparam int ValW   = 32;
  localparam int SumW   = 33;
  localparam int OpW    = 2;
  localparam int StatW  = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW   = 8;

  // operation codes
  localparam logic [OpW-1:0] OpLoadA = 2'd0;
  localparam logic [OpW-1:0] OpLoadB = 2'd1;
  localparam logic [OpW-1:0] OpMerge = 2'd2;

  // result status codes
  localparam logic [StatW-1:0] StatTerm     = 2'd0;
  localparam logic [StatW-1:0] StatMismatch = 2'd1;
  localparam logic [StatW-1:0] StatEmpty    = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgARows = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgACols = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBRows = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgBCols = 2'd3;

  typedef struct packed {
    logic [RowW-1:0]        row;
    logic [ColW-1:0]        col;
    logic signed [ValW-1:0] value;
  } term_t;

  typedef struct packed {
    logic             load_a;
    logic             load_b;
    logic             emit_status;
    logic [StatW-1:0] status;
    logic             step;
    logic             clear;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic shape_match;
    logic both_empty;
    logic merge_last;
  } dp_stat_t;

endpackage

// File: src/stma_in_if.sv
interface stma_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [stma_pkg::OpW-1:0]             operation;
  logic [stma_pkg::RowW-1:0]            row;
  logic [stma_pkg::ColW-1:0]            col;
  logic signed [stma_pkg::ValW-1:0]     value;

  modport source (output valid, output operation, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input operation, input row, input col, input value,
                  output ready);
endinterface

// File: src/stma_out_if.sv
interface stma_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [stma_pkg::StatW-1:0]           status;
  logic [stma_pkg::RowW-1:0]            out_row;
  logic [stma_pkg::ColW-1:0]            out_col;
  logic signed [stma_pkg::SumW-1:0]     out_value;
  logic                                 last;

  modport source (output valid, output status, output out_row, output out_col,
                  output out_value, output last, input ready);
  modport sink   (input valid, input status, input out_row, input out_col,
                  input out_value, input last, output ready);
endinterface

// File: src/stma_ctrl.sv
module stma_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [stma_pkg::OpW-1:0] in_op_i,
  output logic                     in_ready_o,
  input  stma_pkg::dp_stat_t       stat_i,
  output stma_pkg::dp_cmd_t        cmd_o
);

  localparam logic StIdle  = 1'b0;
  localparam logic StMerge = 1'b1;

  logic state_q, state_d;
  logic in_beat;

  assign in_ready_o = (state_q == StIdle) && stat_i.out_free;
  assign in_beat    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_beat) begin
          unique case (in_op_i)
            stma_pkg::OpLoadA: cmd_o.load_a = 1'b1;
            stma_pkg::OpLoadB: cmd_o.load_b = 1'b1;
            stma_pkg::OpMerge: begin
              priority if (!stat_i.shape_match) begin
                cmd_o.emit_status = 1'b1;
                cmd_o.status      = stma_pkg::StatMismatch;
                cmd_o.clear       = 1'b1;
              end else if (stat_i.both_empty) begin
                cmd_o.emit_status = 1'b1;
                cmd_o.status      = stma_pkg::StatEmpty;
                cmd_o.clear       = 1'b1;
              end else begin
                state_d = StMerge;
              end
            end
            default: ;
          endcase
        end
      end
      StMerge: begin
        // one merged term per free output slot
        if (stat_i.out_free) begin
          cmd_o.step = 1'b1;
          if (stat_i.merge_last) begin
            cmd_o.clear = 1'b1;
            state_d     = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/stma_dp.sv
module stma_dp #(
  parameter int MAX_TERMS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  stma_pkg::term_t                  in_term_i,
  input  logic                             cfg_we_i,
  input  logic [stma_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [stma_pkg::CfgW-1:0]        cfg_data_i,
  input  stma_pkg::dp_cmd_t                cmd_i,
  output stma_pkg::dp_stat_t               stat_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [stma_pkg::StatW-1:0]       status_o,
  output logic [stma_pkg::RowW-1:0]        out_row_o,
  output logic [stma_pkg::ColW-1:0]        out_col_o,
  output logic signed [stma_pkg::SumW-1:0] out_value_o,
  output logic                             last_o
);

  localparam int CntW = $clog2(MAX_TERMS + 1);
  localparam int IdxW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_TERMS);

  logic [stma_pkg::CfgW-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [CntW-1:0] a_cnt_q, b_cnt_q, i_q, j_q;
  logic [CntW-1:0] i_d, j_d;

  stma_pkg::term_t a_mem [MAX_TERMS];
  stma_pkg::term_t b_mem [MAX_TERMS];
  stma_pkg::term_t pa, pb;

  logic a_done, b_done, same_pos, a_after, take_a, take_b;
  logic signed [stma_pkg::SumW-1:0] va, vb, sum;

  logic                             out_valid_q;
  logic [stma_pkg::StatW-1:0]       status_q;
  logic [stma_pkg::RowW-1:0]        row_q;
  logic [stma_pkg::ColW-1:0]        col_q;
  logic signed [stma_pkg::SumW-1:0] value_q;
  logic                             last_q;

  // shape registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= stma_pkg::CfgW'(1);
      a_cols_q <= stma_pkg::CfgW'(1);
      b_rows_q <= stma_pkg::CfgW'(1);
      b_cols_q <= stma_pkg::CfgW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        stma_pkg::CfgARows: a_rows_q <= cfg_data_i;
        stma_pkg::CfgACols: a_cols_q <= cfg_data_i;
        stma_pkg::CfgBRows: b_rows_q <= cfg_data_i;
        stma_pkg::CfgBCols: b_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // term stores, full store drops the beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a && (a_cnt_q != CntMax)) begin
      a_mem[a_cnt_q[IdxW-1:0]] <= in_term_i;
    end
    if (cmd_i.load_b && (b_cnt_q != CntMax)) begin
      b_mem[b_cnt_q[IdxW-1:0]] <= in_term_i;
    end
  end

  assign pa = a_mem[i_q[IdxW-1:0]];
  assign pb = b_mem[j_q[IdxW-1:0]];

  assign a_done   = (i_q >= a_cnt_q);
  assign b_done   = (j_q >= b_cnt_q);
  assign same_pos = (pa.row == pb.row) && (pa.col == pb.col);
  assign a_after  = (pa.row > pb.row) || ((pa.row == pb.row) && (pa.col > pb.col));

  always_comb begin
    priority if (a_done) begin
      take_a = 1'b0;
      take_b = 1'b1;
    end else if (b_done) begin
      take_a = 1'b1;
      take_b = 1'b0;
    end else if (same_pos) begin
      take_a = 1'b1;
      take_b = 1'b1;
    end else if (a_after) begin
      take_a = 1'b0;
      take_b = 1'b1;
    end else begin
      take_a = 1'b1;
      take_b = 1'b0;
    end
  end

  assign va  = take_a ? stma_pkg::SumW'(pa.value) : '0;
  assign vb  = take_b ? stma_pkg::SumW'(pb.value) : '0;
  assign sum = va + vb;

  assign i_d = i_q + CntW'(take_a);
  assign j_d = j_q + CntW'(take_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      if (cmd_i.clear) begin
        a_cnt_q <= '0;
        b_cnt_q <= '0;
        i_q     <= '0;
        j_q     <= '0;
      end else begin
        if (cmd_i.load_a && (a_cnt_q != CntMax)) a_cnt_q <= a_cnt_q + CntW'(1);
        if (cmd_i.load_b && (b_cnt_q != CntMax)) b_cnt_q <= b_cnt_q + CntW'(1);
        if (cmd_i.step) begin
          i_q <= i_d;
          j_q <= j_d;
        end
      end
    end
  end

  assign stat_o.out_free    = !out_valid_q || out_ready_i;
  assign stat_o.shape_match = (a_rows_q == b_rows_q) && (a_cols_q == b_cols_q);
  assign stat_o.both_empty  = (a_cnt_q == '0) && (b_cnt_q == '0);
  assign stat_o.merge_last  = (i_d >= a_cnt_q) && (j_d >= b_cnt_q);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_status || cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_status) begin
      status_q <= cmd_i.status;
      row_q    <= '0;
      col_q    <= '0;
      value_q  <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.step) begin
      status_q <= stma_pkg::StatTerm;
      row_q    <= take_a ? pa.row : pb.row;
      col_q    <= take_a ? pa.col : pb.col;
      value_q  <= sum;
      last_q   <= stat_o.merge_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_row_o   = row_q;
  assign out_col_o   = col_q;
  assign out_value_o = value_q;
  assign last_o      = last_q;

endmodule

// File: src/sparse_triplet_matrix_add.sv
// Load beats return no result.
// A merge beat yields a status result in the cycle after the beat; otherwise the
// controller enters its merge state and then registers merged terms, one term per cycle
// while the output is taken, each from the single compare-and-add step over both stores.
// Input is held off until the merge's last term has left the output register.
// Reset clears both counts and sets all shape registers to 1; the stores are not cleared.
module sparse_triplet_matrix_add #(
  parameter int MAX_TERMS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  stma_in_if.sink                      in_if,
  stma_out_if.source                   out_if,
  input  logic                         cfg_we_i,
  input  logic [stma_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [stma_pkg::CfgW-1:0]    cfg_data_i
);

  stma_pkg::dp_cmd_t  cmd;
  stma_pkg::dp_stat_t stat;
  stma_pkg::term_t    in_term;

  assign in_term.row   = in_if.row;
  assign in_term.col   = in_if.col;
  assign in_term.value = in_if.value;

  stma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_op_i    (in_if.operation),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  stma_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_term_i   (in_term),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .status_o    (out_if.status),
    .out_row_o   (out_if.out_row),
    .out_col_o   (out_if.out_col),
    .out_value_o (out_if.out_value),
    .last_o      (out_if.last)
  );

endmodule

// File: src/stma_checker.sv
module stma_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [stma_pkg::StatW-1:0]       status_i,
  input logic [stma_pkg::RowW-1:0]        out_row_i,
  input logic [stma_pkg::ColW-1:0]        out_col_i,
  input logic signed [stma_pkg::SumW-1:0] out_value_i,
  input logic                             last_i
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(out_row_i) && $stable(out_col_i) && $stable(out_value_i) && $stable(last_i))
    else $error("result beat changed while stalled");

  // status results are single, final and zero
  a_status_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != stma_pkg::StatTerm) |->
      last_i && (out_row_i == '0) && (out_col_i == '0) && (out_value_i == '0))
    else $error("malformed status result");

  // no new input while a result is stuck
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !(in_valid_i && in_ready_i))
    else $error("input beat taken while output stalled");

endmodule

bind sparse_triplet_matrix_add stma_checker u_stma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .status_i    (out_if.status),
  .out_row_i   (out_if.out_row),
  .out_col_i   (out_if.out_col),
  .out_value_i (out_if.out_value),
  .last_i      (out_if.last)
);
